FILE: design/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg : shared types and constants for the line rasteriser
// Field widths, register indexes, sequencer states and the control words
// passed to the shared add/subtract unit.
// ----------------------------------------------------------------------------
package slr_pkg;

	localparam int COORD_W   = 9;
	localparam int FRAC_BITS = 16;
	localparam int COL_W     = 8;
	localparam int PITCH_W   = 14;
	localparam int BPP_W     = 3;
	localparam int ADDR_W    = 22;
	localparam int CFG_IDX_W = 1;

	// slope magnitude and the y accumulator (only bits below ACC_W matter)
	localparam int QUO_W = COORD_W + FRAC_BITS;
	localparam int ACC_W = COORD_W + FRAC_BITS + 1;
	localparam int CNT_W = $clog2(QUO_W);

	localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(2048);
	localparam logic [BPP_W-1:0]   BPP_RESET   = BPP_W'(4);

	localparam logic [CFG_IDX_W-1:0] REG_PITCH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BPP   = CFG_IDX_W'(1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_ADDR,
		S_EMIT
	} state_t;

	typedef enum logic {
		ALU_DIV,
		ALU_ACC
	} alu_mode_t;

	typedef struct packed {
		alu_mode_t          mode;
		logic [COORD_W-1:0] rem;
		logic               n_msb;
		logic [COORD_W-1:0] divisor;
		logic [ACC_W-1:0]   acc;
		logic [QUO_W-1:0]   mag;
		logic               dec;
	} alu_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic             neg;
	} alu_rsp_t;

endpackage

FILE: design/slr_alu.sv
// ----------------------------------------------------------------------------
// slr_alu : shared add/subtract unit
// One adder serves the restoring divide step and the y accumulator update.
// ----------------------------------------------------------------------------
module slr_alu (
	input  slr_pkg::alu_req_t req,
	output slr_pkg::alu_rsp_t rsp
);

	logic [slr_pkg::ACC_W-1:0] a;
	logic [slr_pkg::ACC_W-1:0] b;
	logic                      sub;
	logic [slr_pkg::ACC_W-1:0] sum;

	always_comb begin
		unique case (req.mode)
			slr_pkg::ALU_DIV: begin
				// partial remainder with next dividend bit, minus divisor
				a   = slr_pkg::ACC_W'({req.rem, req.n_msb});
				b   = slr_pkg::ACC_W'(req.divisor);
				sub = 1'b1;
			end
			slr_pkg::ALU_ACC: begin
				a   = req.acc;
				b   = slr_pkg::ACC_W'(req.mag);
				sub = req.dec;
			end
			default: begin
				a   = '0;
				b   = '0;
				sub = 1'b0;
			end
		endcase
	end

	assign sum     = a + (sub ? ~b : b) + slr_pkg::ACC_W'(sub);
	assign rsp.sum = sum;
	assign rsp.neg = sum[slr_pkg::ACC_W-1];

endmodule

FILE: design/slr_addr.sv
// ----------------------------------------------------------------------------
// slr_addr : framebuffer byte address
// pitch * y + bytes_per_pixel * x, registered, wrapped to the address width.
// ----------------------------------------------------------------------------
module slr_addr (
	input  logic                         clk,
	input  logic [slr_pkg::PITCH_W-1:0]  pitch,
	input  logic [slr_pkg::BPP_W-1:0]    bpp,
	input  logic [slr_pkg::COORD_W-1:0]  x,
	input  logic [slr_pkg::COORD_W-1:0]  y,
	output logic [slr_pkg::ADDR_W-1:0]   addr_s1
);

	localparam int PY_W = slr_pkg::PITCH_W + slr_pkg::COORD_W;
	localparam int BX_W = slr_pkg::BPP_W + slr_pkg::COORD_W;

	logic [PY_W-1:0] py;
	logic [BX_W-1:0] bx;
	logic [PY_W-1:0] total;

	assign py    = PY_W'(pitch) * PY_W'(y);
	assign bx    = BX_W'(bpp) * BX_W'(x);
	assign total = py + PY_W'(bx);

	always_ff @(posedge clk) begin
		addr_s1 <= total[slr_pkg::ADDR_W-1:0];
	end

endmodule

FILE: design/slope_intercept_line_raster.sv
// ----------------------------------------------------------------------------
// slope_intercept_line_raster : slope-intercept line rasteriser
// Loads a line and divides once for a fixed-point slope unless it is vertical;
// a load or step emits a pixel word: rounded y, colour, framebuffer byte address.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------
//  s_*      | in  | s_tvalid/s_tready | tuser opcode, tdata endpoints+colour
//  m_*      | out | m_tvalid/m_tready | tdata pixel, tlast last_pixel
//  cfg_*    | in  | cfg_wen           | cfg_index, cfg_wdata
//
// Load: accept, then the 25-step shift-subtract division on the shared adder,
//   then the address register, and the output register once it has room.
// Vertical loads and steps skip the divider; steps with no active line are dropped.
// An input word is taken whenever the sequencer is idle, even while the
//   previous pixel word still sits in the output register.
// arst_n clears the sequencer, the line-active flag, the output valid and
//   sets the registers to pitch 2048, 4 bytes per pixel.
// ----------------------------------------------------------------------------
module slope_intercept_line_raster (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,  // x_start, y_start, x_end, y_end,
	                                                  // red_in, green_in, blue_in, pad
	input  logic                            s_tuser,  // opcode

	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [63:0]                     m_tdata,  // pixel_x, pixel_y, byte_address,
	                                                  // red_out, green_out, blue_out
	output logic                            m_tlast,  // last_pixel

	input  logic                            cfg_wen,
	input  logic [slr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slr_pkg::PITCH_W-1:0]     cfg_wdata
);

	localparam int CW = slr_pkg::COORD_W;
	localparam int FB = slr_pkg::FRAC_BITS;

	slr_pkg::state_t state_q, state_d;

	// configuration
	logic [slr_pkg::PITCH_W-1:0] pitch_q;
	logic [slr_pkg::BPP_W-1:0]   bpp_q;

	// line state
	logic [CW-1:0]              cur_x_q;
	logic [CW-1:0]              org_y_q;
	logic [CW-1:0]              tgt_x_q;
	logic [CW-1:0]              adx_q;
	logic [CW-1:0]              rem_q;
	logic [slr_pkg::QUO_W-1:0]  quo_q;    // dividend in, slope magnitude out
	logic [slr_pkg::CNT_W-1:0]  cnt_q;
	logic [slr_pkg::ACC_W-1:0]  acc_q;    // slope*(x - x_start) + one half
	logic                       dx_neg_q;
	logic                       dy_neg_q;
	logic                       active_q;
	logic                       last_q;
	logic [slr_pkg::COL_W-1:0]  red_q, green_q, blue_q;

	// output register
	logic                       m_tvalid_q;
	logic                       m_tlast_q;
	logic [63:0]                m_tdata_q;

	// handshake and decode
	logic accept, do_load, do_step, div_done, out_free, emit;

	// load word fields
	logic [CW-1:0] xs, ys, xe, ye;
	logic [CW-1:0] adx, ady;
	logic          dx_neg, dy_neg, dx_zero;

	// step
	logic [CW-1:0] next_x;
	logic [CW-1:0] pix_y;

	slr_pkg::alu_req_t alu_req;
	slr_pkg::alu_rsp_t alu_rsp;
	logic [slr_pkg::ADDR_W-1:0] addr_s1;

	assign accept   = s_tvalid & s_tready;
	assign do_load  = accept & (s_tuser == slr_pkg::OP_LOAD);
	assign do_step  = accept & (s_tuser == slr_pkg::OP_STEP) & active_q;
	assign div_done = (cnt_q == '0);
	assign out_free = ~m_tvalid_q | m_tready;

	assign xs = s_tdata[CW-1:0];
	assign ys = s_tdata[2*CW-1:CW];
	assign xe = s_tdata[3*CW-1:2*CW];
	assign ye = s_tdata[4*CW-1:3*CW];

	assign dx_neg  = xe < xs;
	assign dy_neg  = ye < ys;
	assign dx_zero = xe == xs;
	assign adx     = dx_neg ? xs - xe : xe - xs;
	assign ady     = dy_neg ? ys - ye : ye - ys;

	// x only moves toward the target, so it never wraps
	assign next_x = dx_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);

	// floor of the accumulator's integer part, modulo the coordinate width
	assign pix_y = org_y_q + acc_q[FB +: CW];

	// shared adder: divide step while dividing, accumulator step otherwise
	always_comb begin
		alu_req.mode    = (state_q == slr_pkg::S_DIV) ? slr_pkg::ALU_DIV : slr_pkg::ALU_ACC;
		alu_req.rem     = rem_q;
		alu_req.n_msb   = quo_q[slr_pkg::QUO_W-1];
		alu_req.divisor = adx_q;
		alu_req.acc     = acc_q;
		alu_req.mag     = quo_q;
		alu_req.dec     = dy_neg_q;
	end

	slr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	slr_addr u_addr (
		.clk     (clk),
		.pitch   (pitch_q),
		.bpp     (bpp_q),
		.x       (cur_x_q),
		.y       (pix_y),
		.addr_s1 (addr_s1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slr_pkg::S_IDLE: begin
				if (do_load) begin
					state_d = dx_zero ? slr_pkg::S_ADDR : slr_pkg::S_DIV;
				end else if (do_step) begin
					state_d = slr_pkg::S_ADDR;
				end
			end
			slr_pkg::S_DIV: begin
				if (div_done) begin
					state_d = slr_pkg::S_ADDR;
				end
			end
			slr_pkg::S_ADDR: begin
				state_d = slr_pkg::S_EMIT;
			end
			slr_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = slr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = slr_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			slr_pkg::S_IDLE: s_tready = 1'b1;
			slr_pkg::S_EMIT: emit     = out_free;
			default: begin
				s_tready = 1'b0;
				emit     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= slr_pkg::PITCH_RESET;
			bpp_q   <= slr_pkg::BPP_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				slr_pkg::REG_PITCH: pitch_q <= cfg_wdata;
				slr_pkg::REG_BPP:   bpp_q   <= cfg_wdata[slr_pkg::BPP_W-1:0];
				default: begin
					pitch_q <= pitch_q;
				end
			endcase
		end
	end

	// line-active flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (do_load) begin
			active_q <= ~dx_zero;
		end else if (do_step) begin
			active_q <= next_x != tgt_x_q;
		end
	end

	// line payload, divider and accumulator
	always_ff @(posedge clk) begin
		if (do_load) begin
			cur_x_q  <= xs;
			org_y_q  <= ys;
			tgt_x_q  <= xe;
			adx_q    <= adx;
			dx_neg_q <= dx_neg;
			dy_neg_q <= dy_neg;
			rem_q    <= '0;
			quo_q    <= {ady, FB'(0)};
			cnt_q    <= slr_pkg::CNT_W'(slr_pkg::QUO_W - 1);
			acc_q    <= slr_pkg::ACC_W'(1) << (FB - 1);
			last_q   <= dx_zero;
			red_q    <= s_tdata[4*CW +: slr_pkg::COL_W];
			green_q  <= s_tdata[4*CW + slr_pkg::COL_W +: slr_pkg::COL_W];
			blue_q   <= s_tdata[4*CW + 2*slr_pkg::COL_W +: slr_pkg::COL_W];
		end else if (do_step) begin
			cur_x_q <= next_x;
			acc_q   <= alu_rsp.sum;
			last_q  <= next_x == tgt_x_q;
		end else if (state_q == slr_pkg::S_DIV) begin
			// restoring step: keep the difference when it did not borrow
			rem_q <= alu_rsp.neg ? {rem_q[CW-2:0], quo_q[slr_pkg::QUO_W-1]}
			                     : alu_rsp.sum[CW-1:0];
			quo_q <= {quo_q[slr_pkg::QUO_W-2:0], ~alu_rsp.neg};
			cnt_q <= cnt_q - slr_pkg::CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {blue_q, green_q, red_q, addr_s1, pix_y, cur_x_q};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	// partial remainder always stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slr_pkg::S_DIV) |-> (rem_q < adx_q))
		else $error("divider remainder out of range");

	// a vertical line must never reach the divider
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slr_pkg::S_DIV) |-> (adx_q != '0))
		else $error("divide by zero");

	// an active line has not yet reached its end point
	a_active_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slr_pkg::S_IDLE && active_q) |-> (cur_x_q != tgt_x_q))
		else $error("active line already at target");

	// every emit leaves the sequencer idle with a pixel word presented
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (state_q == slr_pkg::S_IDLE && m_tvalid_q))
		else $error("pixel word not presented after emit");
`endif

endmodule

FILE: verif/slope_intercept_line_raster_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slope_intercept_line_raster_tb : self-checking bench for the line rasteriser
// Drives load and step words over the input stream and scores every pixel
// word against a cycle-free model of the slope, rounding and addressing, or a
// typed table value. A short hand-written table runs first, then random lines
// under six register settings, most with random back-pressure, and one long output hold-off.
// ----------------------------------------------------------------------------
module slope_intercept_line_raster_tb;

	localparam int HALF_PERIOD = 6;
	localparam int SETTLE      = 40;
	localparam int HOLD_CYCLES = 150;  // long output hold-off
	localparam int STALL_LIMIT = 2000; // cycles with no handshake at all
	localparam int PHASE_WORDS = 240;  // pixel words per random phase
	localparam int N_PHASES    = 6;
	localparam int N_ROWS      = 21;

	// short names for the opcodes in the table
	localparam logic OP_LD = slr_pkg::OP_LOAD;
	localparam logic OP_ST = slr_pkg::OP_STEP;

	// one input word, as carried by tuser/tdata
	typedef struct packed {
		logic                        op;
		logic [slr_pkg::COORD_W-1:0] xs;
		logic [slr_pkg::COORD_W-1:0] ys;
		logic [slr_pkg::COORD_W-1:0] xe;
		logic [slr_pkg::COORD_W-1:0] ye;
		logic [slr_pkg::COL_W-1:0]   r;
		logic [slr_pkg::COL_W-1:0]   g;
		logic [slr_pkg::COL_W-1:0]   b;
	} line_cmd_t;

	// one output word, fields plus tlast
	typedef struct packed {
		logic [slr_pkg::COORD_W-1:0] x;
		logic [slr_pkg::COORD_W-1:0] y;
		logic [slr_pkg::ADDR_W-1:0]  addr;
		logic [slr_pkg::COL_W-1:0]   r;
		logic [slr_pkg::COL_W-1:0]   g;
		logic [slr_pkg::COL_W-1:0]   b;
		logic                        last;
	} pixel_t;

	// how a table row is scored
	typedef enum logic [1:0] {
		CHK_MODEL,  // whatever the line model gives
		CHK_TYPED,  // value written into the row
		CHK_NONE    // no word may come back
	} check_kind_t;

	typedef struct packed {
		line_cmd_t   cmd;
		check_kind_t chk;
		pixel_t      px;
	} dir_row_t;

	localparam pixel_t NO_PIX = '0;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [63:0]                   s_tdata;
	logic                          s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [63:0]                   m_tdata;
	logic                          m_tlast;
	logic                          cfg_wen;
	logic [slr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [slr_pkg::PITCH_W-1:0]   cfg_wdata;

	slope_intercept_line_raster dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Line model state: registers, the line being walked and its colour.
	// ------------------------------------------------------------------
	logic [slr_pkg::PITCH_W-1:0] pitch_q;
	logic [slr_pkg::BPP_W-1:0]   bpp_q;
	logic [slr_pkg::COORD_W-1:0] walk_x;
	logic [slr_pkg::COORD_W-1:0] org_x;
	logic [slr_pkg::COORD_W-1:0] org_y;
	logic [slr_pkg::COORD_W-1:0] end_x;
	longint                      slope_q16;  // signed, FRAC_BITS fraction bits
	logic                        walk_down;
	logic                        tracing;
	logic [slr_pkg::COL_W-1:0]   col_r, col_g, col_b;

	pixel_t pixel_q[$];  // pixel words still owed by the block

	// run bookkeeping
	int  n_loads, n_vert, n_steps_out, n_dead, n_cfg, n_holds;
	int  pix_owed_total;
	int  n_bad;
	bit  src_idle_on, sink_idle_on;
	bit  hold_req;

	// Row layout: opcode, line endpoints, colour, scoring kind, typed pixel word.
	dir_row_t dir_rows [0:N_ROWS-1] = '{
		// step before any line: ignored
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_PIX},
		// full-width shallow line from the origin
		'{'{OP_LD, 9'd0, 9'd0, 9'd511, 9'd383, 8'hff, 8'h00, 8'h80}, CHK_TYPED,
			'{9'd0, 9'd0, 22'd0, 8'hff, 8'h00, 8'h80, 1'b0}},
		'{'{OP_ST, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 8'hff, 8'hff, 8'hff}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		// vertical line cuts the active one short: one word, tlast set
		'{'{OP_LD, 9'd511, 9'd383, 9'd511, 9'd0, 8'h01, 8'h02, 8'h03}, CHK_TYPED,
			'{9'd511, 9'd383, 22'd786428, 8'h01, 8'h02, 8'h03, 1'b1}},
		'{'{OP_ST, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 8'hff, 8'hff, 8'hff}, CHK_NONE, NO_PIX},
		// y above the screen, walking left and down, steep
		'{'{OP_LD, 9'd10, 9'd511, 9'd8, 9'd0, 8'h10, 8'h20, 8'h30}, CHK_TYPED,
			'{9'd10, 9'd511, 22'd1046568, 8'h10, 8'h20, 8'h30, 1'b0}},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		// line already finished
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_PIX},
		// one-step line with the steepest rise
		'{'{OP_LD, 9'd100, 9'd0, 9'd101, 9'd511, 8'h55, 8'haa, 8'h55}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		// right to left, rising: negative slope
		'{'{OP_LD, 9'd511, 9'd0, 9'd0, 9'd511, 8'hff, 8'hff, 8'hff}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		// horizontal line loaded over the active one
		'{'{OP_LD, 9'd5, 9'd5, 9'd7, 9'd5, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		// one step down the full height
		'{'{OP_LD, 9'd0, 9'd383, 9'd1, 9'd0, 8'h7f, 8'h80, 8'h01}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_PIX},
		'{'{OP_ST, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00}, CHK_NONE, NO_PIX}
	};

	// pixel word for (x, y) under the current registers and colour
	function automatic pixel_t pixel_at(logic [slr_pkg::COORD_W-1:0] x,
	                                    logic [slr_pkg::COORD_W-1:0] y, logic last);
		pixel_t p;
		longint a;
		a = longint'(pitch_q) * longint'(y) + longint'(bpp_q) * longint'(x);
		p.x    = x;
		p.y    = y;
		p.addr = a[slr_pkg::ADDR_W-1:0];  // wraps mod 2^22
		p.r    = col_r;
		p.g    = col_g;
		p.b    = col_b;
		p.last = last;
		return p;
	endfunction

	// Advance the line model by one input word.
	task automatic line_predict(input line_cmd_t c, output bit emits, output pixel_t px);
		longint dx, dy, adx, ady, mag, d, acc, yv;
		logic   fin;
		emits = 1'b0;
		px    = NO_PIX;
		if (c.op == slr_pkg::OP_LOAD) begin
			dx    = longint'(c.xe) - longint'(c.xs);
			dy    = longint'(c.ye) - longint'(c.ys);
			col_r = c.r;
			col_g = c.g;
			col_b = c.b;
			org_x = c.xs;
			org_y = c.ys;
			end_x = c.xe;
			walk_x = c.xs;
			emits = 1'b1;
			if (dx == 0) begin
				// vertical: start pixel only, line closed at once
				slope_q16 = 0;
				walk_down = 1'b0;
				tracing   = 1'b0;
				px = pixel_at(c.xs, c.ys, 1'b1);
			end else begin
				adx = (dx < 0) ? -dx : dx;
				ady = (dy < 0) ? -dy : dy;
				mag = (ady << slr_pkg::FRAC_BITS) / adx;  // truncated magnitude
				slope_q16 = ((dx < 0) != (dy < 0)) ? -mag : mag;
				walk_down = (dx < 0);
				tracing   = 1'b1;
				px = pixel_at(c.xs, c.ys, 1'b0);
			end
		end else if (tracing) begin
			walk_x = walk_down ? walk_x - 1'b1 : walk_x + 1'b1;
			d   = longint'(walk_x) - longint'(org_x);
			acc = slope_q16 * d + (longint'(1) << (slr_pkg::FRAC_BITS - 1));
			yv  = longint'(org_y) + (acc >>> slr_pkg::FRAC_BITS);  // floor, either sign
			fin = (walk_x == end_x);
			if (fin)
				tracing = 1'b0;
			emits = 1'b1;
			px = pixel_at(walk_x, yv[slr_pkg::COORD_W-1:0], fin);
		end
	endtask

	// Offer one word; on acceptance update the model and owe its pixel.
	task automatic send_cmd(input line_cmd_t c, input check_kind_t chk, input pixel_t typed);
		bit     emits;
		pixel_t px;
		s_tvalid <= 1'b1;
		s_tuser  <= c.op;
		s_tdata  <= {4'b0, c.b, c.g, c.r, c.ye, c.xe, c.ys, c.xs};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		line_predict(c, emits, px);
		if (c.op == slr_pkg::OP_LOAD) begin
			n_loads++;
			if (c.xs == c.xe)
				n_vert++;
		end else if (emits) begin
			n_steps_out++;
		end else begin
			n_dead++;
		end
		if (emits)
			pix_owed_total++;
		if (chk == CHK_MODEL && emits)
			pixel_q.push_back(px);
		else if (chk == CHK_TYPED)
			pixel_q.push_back(typed);
		// idle burst on the input side
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Register write; the model follows at the same edge.
	task automatic cfg_write(input logic [slr_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [slr_pkg::PITCH_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == slr_pkg::REG_PITCH)
			pitch_q = val;
		else
			bpp_q = val[slr_pkg::BPP_W-1:0];
		n_cfg++;
	endtask

	// One random line: a load, then mostly a full walk to its end; a few
	// walks are cut short by the next load, a few run past the end. The
	// walk never goes beyond the words left in the phase.
	task automatic random_line(input int room);
		line_cmd_t c;
		line_cmd_t junk;
		int        span, sel, xe_i, n_walk;
		c.op = slr_pkg::OP_LOAD;
		c.xs = 9'($urandom);
		sel  = $urandom_range(0, 19);
		if (sel < 2)
			span = 0;
		else if (sel < 14)
			span = $urandom_range(1, 12);
		else if (sel < 19)
			span = $urandom_range(13, 80);
		else
			span = $urandom_range(81, 511);
		xe_i = $urandom_range(0, 1) ? int'(c.xs) + span : int'(c.xs) - span;
		if (xe_i > 511)
			xe_i = int'(c.xs) - span;
		if (xe_i < 0)
			xe_i = int'(c.xs) + span;
		if (xe_i > 511)
			xe_i = 511;
		c.xe = 9'(xe_i);
		span = (xe_i > int'(c.xs)) ? xe_i - int'(c.xs) : int'(c.xs) - xe_i;
		c.ys = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 383));
		sel  = $urandom_range(0, 7);
		if (sel == 0)
			c.ye = c.ys;
		else if (sel == 1)
			c.ye = 9'($urandom);
		else
			c.ye = 9'($urandom_range(0, 383));
		c.r = 8'($urandom);
		c.g = 8'($urandom);
		c.b = 8'($urandom);
		send_cmd(c, CHK_MODEL, NO_PIX);

		n_walk = span;
		sel = $urandom_range(0, 19);
		if (sel < 3)
			n_walk = $urandom_range(0, span);
		else if (sel < 5)
			n_walk = span + $urandom_range(1, 2);
		if (n_walk > room - 1)
			n_walk = room - 1;
		repeat (n_walk) begin
			// endpoint and colour fields of a step carry noise
			junk    = line_cmd_t'(61'({$urandom, $urandom}));
			junk.op = slr_pkg::OP_STEP;
			send_cmd(junk, CHK_MODEL, NO_PIX);
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: random tready, one long hold-off on request, scoring.
	// ------------------------------------------------------------------
	initial begin : pixel_sink
		int     hold_left;
		pixel_t got;
		pixel_t want;
		hold_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got = {m_tdata[8:0], m_tdata[17:9], m_tdata[39:18],
				       m_tdata[47:40], m_tdata[55:48], m_tdata[63:56], m_tlast};
				if (pixel_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: pixel word with nothing owed: x=%0d y=%0d addr=%0d last=%0b",
						         $time, got.x, got.y, got.addr, got.last);
				end else begin
					want = pixel_q.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("%0t: pixel mismatch exp/got x %0d/%0d y %0d/%0d addr %0d/%0d",
							         $time, want.x, got.x, want.y, got.y, want.addr, got.addr);
							$display("     rgb %h%h%h/%h%h%h last %0b/%0b",
							         want.r, want.g, want.b, got.r, got.g, got.b,
							         want.last, got.last);
						end
					end
				end
			end
			// next cycle's tready
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				n_holds++;
				m_tready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Ends the run if neither stream moves before the quiet count reaches STALL_LIMIT.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
			    (m_tvalid === 1'b1 && m_tready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles, %0d pixel words still owed",
		         $time, STALL_LIMIT, pixel_q.size());
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, table, then random phases per register setting.
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [slr_pkg::PITCH_W-1:0] ph_pitch [0:N_PHASES-1];
		logic [slr_pkg::BPP_W-1:0]   ph_bpp   [0:N_PHASES-1];
		int                          mark;

		// register extremes first, a random pair last
		ph_pitch = '{14'd0, 14'd8192, 14'd16383, 14'd640, 14'd1, 14'($urandom_range(0, 16383))};
		ph_bpp   = '{3'd1, 3'd4, 3'd7, 3'd0, 3'd2, 3'($urandom_range(0, 7))};

		n_loads = 0; n_vert = 0; n_steps_out = 0; n_dead = 0; n_cfg = 0; n_holds = 0;
		pix_owed_total = 0; n_bad = 0;
		hold_req = 1'b0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;

		// model matches the block's reset values
		pitch_q = slr_pkg::PITCH_RESET;
		bpp_q   = slr_pkg::BPP_RESET;
		walk_x = '0; org_x = '0; org_y = '0; end_x = '0;
		slope_q16 = 0; walk_down = 1'b0; tracing = 1'b0;
		col_r = '0; col_g = '0; col_b = '0;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= slr_pkg::OP_LOAD;
		cfg_wen   <= 1'b0;
		cfg_index <= slr_pkg::REG_PITCH;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset register values
		for (int i = 0; i < N_ROWS; i++)
			send_cmd(dir_rows[i].cmd, dir_rows[i].chk, dir_rows[i].px);
		s_tvalid <= 1'b0;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// registers change only with the block drained and idle
			wait (pixel_q.size() == 0);
			repeat (SETTLE) @(posedge clk);
			cfg_write(slr_pkg::REG_PITCH, ph_pitch[ph]);
			// upper data bits are noise on the bytes-per-pixel write
			cfg_write(slr_pkg::REG_BPP, {11'($urandom), ph_bpp[ph]});
			cfg_wen <= 1'b0;

			// phase 3 and the closing phase run at full rate both sides
			src_idle_on  = (ph != 3 && ph != N_PHASES - 1);
			sink_idle_on = src_idle_on;
			// long hold-off while input keeps coming: block fills, tready drops
			if (ph == 1)
				hold_req = 1'b1;

			mark = pix_owed_total;
			while (pix_owed_total - mark < PHASE_WORDS)
				random_line(PHASE_WORDS - (pix_owed_total - mark));
			s_tvalid <= 1'b0;
		end

		wait (pixel_q.size() == 0);
		repeat (SETTLE) @(posedge clk);

		$display("Run: %0d line loads (%0d vertical), %0d stepped pixels, %0d steps ignored,",
		         n_loads, n_vert, n_steps_out, n_dead);
		$display("     %0d register writes over %0d settings, %0d long hold-offs, %0d bad words.",
		         n_cfg, N_PHASES, n_holds, n_bad);
		if (n_bad == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
